@@ design/pqmf_pkg.sv @@
`timescale 1ns / 1ps

package pqmf_pkg;

   localparam int DEF_BANDS     = 16;
   localparam int DEF_TAPS      = 205;
   localparam int DEF_ATTEN_DB  = 100;
   localparam int DEF_COEF_BITS = 18;

   localparam int SAMPLE_W = 16;
   localparam int IDX_W    = 4;

   typedef logic [63:0]        u64_type;
   typedef logic signed [63:0] s64_type;

   localparam u64_type ONE20       = 64'd1 << 20;
   localparam u64_type ONE30       = 64'd1 << 30;
   localparam u64_type HALF_PI_Q30 = 64'd1686629713;
   localparam u64_type PI_Q30      = 64'd3373259426;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_ABS,
      ST_ROUND,
      ST_OUT,
      ST_SHIFT
   } state_type;

   typedef struct packed {
      logic             capture;
      logic             frame_start;
      logic             band_start;
      logic             issue;
      logic             finish_abs;
      logic             finish_round;
      logic             shift_in;
      logic             negate;
      logic             band_last;
      logic [IDX_W-1:0] band_index;
   } cmd_type;

   typedef struct packed {
      logic tap_last;
      logic acc_done;
   } status_type;

   // shift and subtract quotient, divisor below 2^63
   function automatic u64_type udiv64(input u64_type num, input u64_type den);
      u64_type quo;
      u64_type rem;
      quo = 64'd0;
      rem = 64'd0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem = rem - den;
            quo = quo | (64'd1 << b);
         end
      end
      return quo;
   endfunction

   // Q30 Taylor series: cosine when odd is 0, sine when odd is 1, on 0..pi/2
   function automatic s64_type series_q30(input u64_type u, input logic odd);
      u64_type u2;
      u64_type term;
      u64_type a;
      s64_type sum;
      u2   = (u * u) >> 30;
      term = odd ? u : ONE30;
      sum  = s64_type'(term);
      for (int i = 1; i < 12; i++) begin
         a    = u64_type'(2 * i - 1) + u64_type'(odd);
         term = udiv64((term * u2) >> 30, a * (a + 64'd1));
         if (i[0]) begin
            sum = sum - s64_type'(term);
         end else begin
            sum = sum + s64_type'(term);
         end
      end
      return sum;
   endfunction

   // cos(2*pi*num/den) in Q30
   function automatic s64_type cos_turns(input s64_type num, input s64_type den);
      s64_type x;
      u64_type mag_n;
      u64_type rem_n;
      u64_type q4;
      u64_type quad;
      u64_type r;
      u64_type u;
      s64_type res;
      mag_n = u64_type'((num < 0) ? -num : num);
      rem_n = mag_n - udiv64(mag_n, u64_type'(den)) * u64_type'(den);
      if (num < 0 && rem_n != 64'd0) begin
         x = den - s64_type'(rem_n);
      end else begin
         x = s64_type'(rem_n);
      end
      q4   = u64_type'(x) * 64'd4;
      quad = udiv64(q4, u64_type'(den));
      r    = q4 - quad * u64_type'(den);
      u    = udiv64(r * HALF_PI_Q30, u64_type'(den));
      case (quad)
         64'd0:   res = series_q30(u, 1'b0);
         64'd1:   res = -series_q30(u, 1'b1);
         64'd2:   res = -series_q30(u, 1'b0);
         default: res = series_q30(u, 1'b1);
      endcase
      return res;
   endfunction

   function automatic u64_type isqrt64(input u64_type v_in);
      u64_type v;
      u64_type r;
      u64_type b_mask;
      v      = v_in;
      r      = 64'd0;
      b_mask = 64'd1 << 62;
      while (b_mask > v) begin
         b_mask = b_mask >> 2;
      end
      while (b_mask != 64'd0) begin
         if (v >= r + b_mask) begin
            v = v - (r + b_mask);
            r = (r >> 1) + b_mask;
         end else begin
            r = r >> 1;
         end
         b_mask = b_mask >> 2;
      end
      return r;
   endfunction

   // largest Q20 y with y^5 <= x^2
   function automatic u64_type pow04_q20(input u64_type x);
      u64_type y;
      u64_type target;
      u64_type c;
      u64_type p2;
      u64_type p4;
      u64_type p5;
      y      = 64'd0;
      target = (x * x) << 20;
      for (int b = 23; b >= 0; b--) begin
         c  = y | (64'd1 << b);
         p2 = (c * c) >> 20;
         p4 = (p2 * p2) >> 20;
         p5 = (p4 * c) >> 20;
         if (p5 <= target) begin
            y = c;
         end
      end
      return y;
   endfunction

   function automatic u64_type i0_q20(input u64_type x);
      u64_type h;
      u64_type sum;
      u64_type term;
      logic    done;
      h    = x >> 1;
      sum  = ONE20;
      term = ONE20;
      done = 1'b0;
      for (int k = 1; k < 50; k++) begin
         if (!done) begin
            term = udiv64((term * h) >> 20, u64_type'(k));
            term = udiv64((term * h) >> 20, u64_type'(k));
            if (term == 64'd0) begin
               done = 1'b1;
            end else begin
               sum = sum + term;
            end
         end
      end
      return sum;
   endfunction

   function automatic u64_type beta_q20(input int atten_db);
      s64_type a;
      u64_type d;
      u64_type res;
      a = s64_type'(atten_db);
      if (a < 20) begin
         a = 20;
      end
      if (a > 140) begin
         a = 140;
      end
      if (a > 50) begin
         res = udiv64(u64_type'(1102 * (10 * a - 87)) << 20, 64'd100000);
      end else if (a >= 21) begin
         d   = u64_type'(a - 21);
         res = udiv64(64'd5842 * pow04_q20(d), 64'd10000)
               + udiv64((64'd7886 * d) << 20, 64'd100000);
      end else begin
         res = 64'd0;
      end
      return res;
   endfunction

   function automatic u64_type window_q20(input s64_type n, input s64_type taps,
                                          input u64_type beta, input u64_type i0b);
      s64_type m;
      u64_type prod;
      u64_type inside_v;
      u64_type s;
      u64_type x;
      u64_type res;
      m = taps - 1;
      if (m <= 0) begin
         res = ONE20;
      end else begin
         prod = u64_type'(n * (m - n));
         if (prod == 64'd0) begin
            res = 64'd0;
         end else begin
            inside_v = udiv64((64'd4 * prod) << 40, u64_type'(m) * u64_type'(m));
            s        = isqrt64(inside_v);
            x        = (beta * s) >> 20;
            res      = udiv64(i0_q20(x) << 20, i0b);
         end
      end
      return res;
   endfunction

   // signed prototype tap: sinc times window, magnitude in Q30
   function automatic s64_type proto_q30(input s64_type n, input s64_type taps,
                                         input s64_type bands, input u64_type beta,
                                         input u64_type i0b);
      s64_type t;
      s64_type sn;
      u64_type at;
      u64_type as_v;
      u64_type sinc;
      u64_type w;
      u64_type pm;
      logic    neg_p;
      t     = n - ((taps - 1) >>> 1);
      w     = window_q20(n, taps, beta, i0b);
      neg_p = 1'b0;
      if (t == 0) begin
         sinc = udiv64(ONE30, u64_type'(bands));
      end else begin
         sn    = cos_turns(4 * t - 2 * bands, 8 * bands);
         at    = u64_type'((t < 0) ? -t : t);
         as_v  = u64_type'((sn < 0) ? -sn : sn);
         sinc  = udiv64(as_v << 30, PI_Q30 * at);
         neg_p = (sn < 0) != (t < 0);
      end
      pm = (sinc * w) >> 20;
      return neg_p ? -s64_type'(pm) : s64_type'(pm);
   endfunction

   function automatic s64_type coef_value(input s64_type pm_s, input s64_type n,
                                          input s64_type k, input s64_type taps,
                                          input s64_type bands, input int coef_bits);
      s64_type tm;
      s64_type ang;
      s64_type c;
      u64_type cm;
      u64_type pm;
      u64_type mag;
      u64_type lim;
      int      sh;
      logic    neg;
      s64_type v;
      tm  = n - (taps >>> 1);
      ang = 2 * (2 * k + 1) * tm + (k[0] ? -bands : bands);
      c   = cos_turns(ang, 8 * bands);
      cm  = u64_type'((c < 0) ? -c : c);
      pm  = u64_type'((pm_s < 0) ? -pm_s : pm_s);
      sh  = 60 - (coef_bits - 1);
      mag = (64'd2 * pm * cm + (64'd1 << (sh - 1))) >> sh;
      neg = (pm_s < 0) != (c < 0);
      lim = 64'd1 << (coef_bits - 1);
      if (neg) begin
         v = (mag > lim) ? -s64_type'(lim) : -s64_type'(mag);
      end else begin
         v = (mag > lim - 64'd1) ? s64_type'(lim - 64'd1) : s64_type'(mag);
      end
      return v;
   endfunction

endpackage

@@ design/pqmf_analysis_filter_bank_top.sv @@
// PQMF analysis filter bank, one audio channel. Each transaction on req_ carries one signed
// Q1.15 sample; on the first sample and every BANDS-th sample after it the block returns
// BANDS transactions on rsp_, bands 0 to BANDS-1 in order with rsp_last on the final one,
// each the TAPS-tap dot product of the sample history with that band's coefficients,
// rounded and saturated to Q1.15. A frame sample is processed by one multiply-accumulate
// unit that handles one tap per cycle, fed by the history RAM and the coefficient ROM
// over one read port each; req_stall stays high until the frame is done, so the block
// takes no new sample before it is through with the last one.
`timescale 1ns / 1ps

module pqmf_analysis_filter_bank_top
   import pqmf_pkg::*;
#(
   parameter int BANDS     = DEF_BANDS,
   parameter int TAPS      = DEF_TAPS,
   parameter int ATTEN_DB  = DEF_ATTEN_DB,
   parameter int COEF_BITS = DEF_COEF_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_band_value,
   output logic [IDX_W-1:0]           rsp_band_index,
   output logic                       rsp_last
);

   cmd_type    cmd;
   status_type status;

   pqmf_ctrl #(
      .BANDS (BANDS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   pqmf_datapath #(
      .BANDS     (BANDS),
      .TAPS      (TAPS),
      .ATTEN_DB  (ATTEN_DB),
      .COEF_BITS (COEF_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_sample     (req_sample),
      .cmd            (cmd),
      .status         (status),
      .rsp_band_value (rsp_band_value),
      .rsp_band_index (rsp_band_index),
      .rsp_last       (rsp_last)
   );

endmodule

@@ design/pqmf_coef_rom.sv @@
`timescale 1ns / 1ps

module pqmf_coef_rom
   import pqmf_pkg::*;
#(
   parameter int BANDS     = DEF_BANDS,
   parameter int TAPS      = DEF_TAPS,
   parameter int ATTEN_DB  = DEF_ATTEN_DB,
   parameter int COEF_BITS = DEF_COEF_BITS,
   localparam int DEPTH    = BANDS * TAPS,
   localparam int AW       = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic [AW-1:0]               addr,
   output logic signed [COEF_BITS-1:0] rd_data
);

   localparam u64_type BETA = beta_q20(ATTEN_DB);
   localparam u64_type I0B  = i0_q20(BETA);

   logic signed [COEF_BITS-1:0] rom [DEPTH];
   logic signed [COEF_BITS-1:0] rd_data_ff;

   for (genvar n = 0; n < TAPS; n++) begin : g_tap
      localparam s64_type PM = proto_q30(n, TAPS, BANDS, BETA, I0B);
      for (genvar k = 0; k < BANDS; k++) begin : g_band
         localparam s64_type CV = coef_value(PM, n, k, TAPS, BANDS, COEF_BITS);
         assign rom[k * TAPS + n] = COEF_BITS'(CV);
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= rom[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/pqmf_datapath.sv @@
`timescale 1ns / 1ps

module pqmf_datapath
   import pqmf_pkg::*;
#(
   parameter int BANDS     = DEF_BANDS,
   parameter int TAPS      = DEF_TAPS,
   parameter int ATTEN_DB  = DEF_ATTEN_DB,
   parameter int COEF_BITS = DEF_COEF_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  cmd_type                    cmd,
   output status_type                 status,
   output logic signed [SAMPLE_W-1:0] rsp_band_value,
   output logic [IDX_W-1:0]           rsp_band_index,
   output logic                       rsp_last
);

   localparam int HIST      = TAPS - 1;
   localparam int DL_AW     = $clog2(HIST);
   localparam int TAP_W     = $clog2(TAPS);
   localparam int FILL_W    = $clog2(HIST + 1);
   localparam int ROM_DEPTH = BANDS * TAPS;
   localparam int CA_W      = $clog2(ROM_DEPTH);
   localparam int PROD_W    = COEF_BITS + SAMPLE_W;
   localparam int ACC_W     = PROD_W + $clog2(TAPS);
   localparam int CF        = COEF_BITS - 1;
   localparam int R_W       = ACC_W + 1 - CF;

   localparam logic [ACC_W:0]  HALF_LSB = (ACC_W + 1)'(1) << (CF - 1);
   localparam logic [R_W-1:0]  POS_MAX  = R_W'(32767);
   localparam logic [R_W-1:0]  NEG_MAX  = R_W'(32768);

   logic signed [SAMPLE_W-1:0] dl_mem [HIST];

   logic signed [SAMPLE_W-1:0]  x_ff;
   logic [DL_AW-1:0]            wr_ptr_ff, wr_ptr_in;
   logic [DL_AW-1:0]            rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]           fill_ff, fill_in;
   logic [TAP_W-1:0]            tap_ff, tap_in;
   logic [CA_W-1:0]             coef_addr_ff, coef_addr_in;
   logic signed [COEF_BITS-1:0] coef_rd;
   logic signed [SAMPLE_W-1:0]  dl_rd_ff;

   logic                        s1_valid_ff, s1_use_dl_ff, s1_use_x_ff, s1_first_ff, s1_last_ff;
   logic                        tap_in_window, tap_is_new;
   logic signed [SAMPLE_W-1:0]  operand;
   logic signed [PROD_W-1:0]    prod_ff, prod_in;
   logic                        s2_valid_ff, s2_first_ff, s2_last_ff;
   logic signed [ACC_W-1:0]     acc_ff, acc_in;
   logic                        acc_done_ff;

   logic [ACC_W-1:0]            mag_ff, mag_in;
   logic                        neg_ff;
   logic [ACC_W:0]              r_sum;
   logic [R_W-1:0]              r_val;
   logic signed [SAMPLE_W-1:0]  band_value_ff, band_value_in;
   logic [IDX_W-1:0]            band_index_ff;
   logic                        last_ff;

   pqmf_coef_rom #(
      .BANDS     (BANDS),
      .TAPS      (TAPS),
      .ATTEN_DB  (ATTEN_DB),
      .COEF_BITS (COEF_BITS)
   ) u_coef_rom (
      .clock   (clock),
      .addr    (coef_addr_ff),
      .rd_data (coef_rd)
   );

   always_comb begin
      wr_ptr_in    = wr_ptr_ff;
      fill_in      = fill_ff;
      rd_ptr_in    = rd_ptr_ff;
      tap_in       = tap_ff;
      coef_addr_in = coef_addr_ff;
      if (cmd.shift_in) begin
         wr_ptr_in = (wr_ptr_ff == DL_AW'(HIST - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (fill_ff != FILL_W'(HIST)) begin
            fill_in = fill_ff + 1'b1;
         end
      end
      if (cmd.band_start) begin
         rd_ptr_in = wr_ptr_ff;
         tap_in    = '0;
      end else if (cmd.issue) begin
         rd_ptr_in = (rd_ptr_ff == DL_AW'(HIST - 1)) ? '0 : rd_ptr_ff + 1'b1;
         tap_in    = tap_ff + 1'b1;
      end
      if (cmd.frame_start) begin
         coef_addr_in = '0;
      end else if (cmd.issue) begin
         coef_addr_in = coef_addr_ff + 1'b1;
      end
   end

   assign tap_is_new    = (tap_ff == TAP_W'(HIST));
   assign tap_in_window = ((TAP_W + 1)'(tap_ff) + (TAP_W + 1)'(fill_ff))
                          >= (TAP_W + 1)'(HIST);

   always_ff @(posedge clock) begin
      if (cmd.shift_in) begin
         dl_mem[wr_ptr_ff] <= x_ff;
      end
      dl_rd_ff <= dl_mem[rd_ptr_ff];
   end

   always_comb begin
      if (s1_use_x_ff) begin
         operand = x_ff;
      end else if (s1_use_dl_ff) begin
         operand = dl_rd_ff;
      end else begin
         operand = '0;
      end
      prod_in = coef_rd * operand;
      acc_in  = s2_first_ff ? ACC_W'(prod_ff) : acc_ff + ACC_W'(prod_ff);
      mag_in  = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
      r_sum   = {1'b0, mag_ff} + HALF_LSB;
      r_val   = r_sum[ACC_W:CF];
      if (neg_ff) begin
         band_value_in = (r_val > NEG_MAX) ? -16'sd32768 : SAMPLE_W'(R_W'(0) - r_val);
      end else begin
         band_value_in = (r_val > POS_MAX) ? 16'sd32767 : SAMPLE_W'(r_val);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         fill_ff     <= '0;
         rd_ptr_ff   <= '0;
         tap_ff      <= '0;
         coef_addr_ff <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         acc_done_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         fill_ff      <= fill_in;
         rd_ptr_ff    <= rd_ptr_in;
         tap_ff       <= tap_in;
         coef_addr_ff <= coef_addr_in;
         s1_valid_ff  <= cmd.issue;
         s2_valid_ff  <= s1_valid_ff;
         acc_done_ff  <= s2_valid_ff & s2_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff <= req_sample;
      end
      s1_use_x_ff  <= tap_is_new;
      s1_use_dl_ff <= ~tap_is_new & tap_in_window;
      s1_first_ff  <= (tap_ff == '0);
      s1_last_ff   <= (tap_ff == TAP_W'(TAPS - 1));
      prod_ff      <= prod_in;
      s2_first_ff  <= s1_first_ff;
      s2_last_ff   <= s1_last_ff;
      if (s2_valid_ff) begin
         acc_ff <= acc_in;
      end
      if (cmd.finish_abs) begin
         mag_ff <= mag_in;
         neg_ff <= acc_ff[ACC_W-1] ^ cmd.negate;
      end
      if (cmd.finish_round) begin
         band_value_ff <= band_value_in;
         band_index_ff <= cmd.band_index;
         last_ff       <= cmd.band_last;
      end
   end

   assign status.tap_last = (tap_ff == TAP_W'(TAPS - 1));
   assign status.acc_done = acc_done_ff;

   assign rsp_band_value = band_value_ff;
   assign rsp_band_index = band_index_ff;
   assign rsp_last       = last_ff;

endmodule

@@ design/pqmf_ctrl.sv @@
`timescale 1ns / 1ps

module pqmf_ctrl
   import pqmf_pkg::*;
#(
   parameter int BANDS = DEF_BANDS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output cmd_type    cmd,
   input  status_type status
);

   localparam int BAND_W = $clog2(BANDS);

   state_type         state_ff, state_in;
   logic [BAND_W-1:0] band_ff, band_in;
   logic [BAND_W-1:0] phase_ff, phase_in;
   logic              parity_ff, parity_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         band_ff   <= '0;
         phase_ff  <= '0;
         parity_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         band_ff   <= band_in;
         phase_ff  <= phase_in;
         parity_ff <= parity_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      band_in   = band_ff;
      phase_in  = phase_ff;
      parity_in = parity_ff;
      cmd              = '0;
      cmd.negate       = band_ff[0] & ~parity_ff;
      cmd.band_last    = (band_ff == BAND_W'(BANDS - 1));
      cmd.band_index   = IDX_W'(band_ff);
      req_stall        = (state_ff != ST_IDLE);
      rsp_valid        = (state_ff == ST_OUT);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (phase_ff == '0) begin
                  cmd.frame_start = 1'b1;
                  cmd.band_start  = 1'b1;
                  band_in         = '0;
                  state_in        = ST_MAC;
               end else begin
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_MAC: begin
            cmd.issue = 1'b1;
            if (status.tap_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (status.acc_done) begin
               state_in = ST_ABS;
            end
         end
         ST_ABS: begin
            cmd.finish_abs = 1'b1;
            state_in       = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.finish_round = 1'b1;
            state_in         = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               if (band_ff == BAND_W'(BANDS - 1)) begin
                  state_in = ST_SHIFT;
               end else begin
                  band_in        = band_ff + 1'b1;
                  cmd.band_start = 1'b1;
                  state_in       = ST_MAC;
               end
            end
         end
         ST_SHIFT: begin
            cmd.shift_in = 1'b1;
            phase_in     = (phase_ff == BAND_W'(BANDS - 1)) ? '0 : phase_ff + 1'b1;
            if (phase_ff == '0) begin
               parity_in = ~parity_ff;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ design/pqmf_checker.sv @@
`timescale 1ns / 1ps

module pqmf_checker
   import pqmf_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic signed [SAMPLE_W-1:0] req_sample,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic signed [SAMPLE_W-1:0] rsp_band_value,
   input logic [IDX_W-1:0]           rsp_band_index,
   input logic                       rsp_last
);

   // hold a stalled result transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_band_value)
         && $stable(rsp_band_index) && $stable(rsp_last))
      else $error("stalled result transaction changed");

   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while a result is pending");

   a_req_then_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not blocked after a sample transaction");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a frame in progress");

endmodule

bind pqmf_analysis_filter_bank_top pqmf_checker u_checker (.*);
